// File: rtl/fsps_pkg.sv
// Package for the filtered stable priority sort.
// Holds sizes, the stream field layout, the list entry type and the state encoding.
// No dependencies.
`timescale 1ns / 1ps

package fsps_pkg;

  // Sizing of the sorted list.
  localparam int unsigned SLOT_COUNT = 32;
  localparam int unsigned KEY_BITS   = 16;

  // Fixed field widths of the stream items.
  localparam int unsigned ID_W       = 5;
  localparam int unsigned IN_KEY_W   = 16;
  localparam int unsigned RANK_W     = 5;
  localparam int unsigned TOTAL_W    = 6;

  // Derived sizes.
  localparam int unsigned KEY_W  = (KEY_BITS < IN_KEY_W) ? KEY_BITS : IN_KEY_W;
  localparam int unsigned ADDR_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CNT_W  = $clog2(SLOT_COUNT + 1);

  // Input tdata: slot_id, sort_key, padded to whole bytes.
  localparam int unsigned IN_ID_LSB    = 0;
  localparam int unsigned IN_KEY_LSB   = IN_ID_LSB + ID_W;
  localparam int unsigned IN_USED_W    = IN_KEY_LSB + IN_KEY_W;
  localparam int unsigned IN_DATA_W    = ((IN_USED_W + 7) / 8) * 8;
  // Input tuser: is_defined, is_visible.
  localparam int unsigned USER_DEF_BIT = 0;
  localparam int unsigned USER_VIS_BIT = 1;
  localparam int unsigned IN_USER_W    = 2;
  // Output tdata: ordered_id, rank, total.
  localparam int unsigned OUT_USED_W   = ID_W + RANK_W + TOTAL_W;
  localparam int unsigned OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

  // One list entry as kept in the memory.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

endpackage

// File: rtl/fsps_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No package dependencies.
`timescale 1ns / 1ps

module fsps_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/filtered_stable_priority_sort.sv
// Top level of the filtered stable priority sort.
// Depends on fsps_pkg and on the generic RAM fsps_ram.
//
//   Channel  Dir  tdata (low bit first)            tuser                    tlast
//   s_axis   in   slot_id[5], sort_key[16], pad[3] is_defined, is_visible  batch_end
//   m_axis   out  ordered_id[5], rank[5], total[6] -                        final_result
//
// An item that is not both defined and visible is not listed. A qualifying
// item is inserted by a downward scan through the list memory, one entry per
// cycle, or written straight to the front of an empty list; the scan is bound
// by the single read and write port of the memory.
// On batch_end each result item is read from the memory and then loaded into
// the output register; the readout waits while a result item is still held.
// Reset clears the list length and all handshake state; the memory needs no
// clearing since only entries below the list length are ever read.
// A stall on m_axis holds the output register and pauses the readout only.
`timescale 1ns / 1ps

module filtered_stable_priority_sort
  import fsps_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,   // slot_id, sort_key, zero pad
  input  logic [IN_USER_W-1:0]  s_axis_tuser_i,   // is_defined, is_visible
  input  logic                  s_axis_tlast_i,   // batch_end
  // Result items.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // ordered_id, rank, total
  output logic                  m_axis_tlast_o    // final_result
);

  // Control registers.
  state_e           state_q, state_d;
  logic [CNT_W-1:0] len_q, len_d;     // number of listed entries
  logic [CNT_W-1:0] pos_q, pos_d;     // hole position during an insertion
  logic [CNT_W-1:0] k_q, k_d;         // readout position
  logic             last_q;           // batch_end of the item being inserted
  logic             m_valid_q, m_valid_d;

  // Payload registers.
  entry_t                new_q;
  logic [OUT_DATA_W-1:0] m_data_q;
  logic                  m_last_q;

  // Memory port signals.
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [ADDR_W-1:0] ram_raddr;
  entry_t            ram_rdata;

  logic             capture;
  logic             out_load;
  logic             out_last;
  entry_t           in_entry;
  logic             in_qualify;
  logic [CNT_W-1:0] len_m1;
  logic [CNT_W-1:0] pos_m1;
  logic [CNT_W-1:0] pos_m2;

  assign in_entry.id  = s_axis_tdata_i[IN_ID_LSB +: ID_W];
  assign in_entry.key = s_axis_tdata_i[IN_KEY_LSB +: KEY_W];
  assign in_qualify   = s_axis_tuser_i[USER_DEF_BIT] & s_axis_tuser_i[USER_VIS_BIT]
                      & (len_q < CNT_W'(SLOT_COUNT));

  assign len_m1   = len_q - CNT_W'(1);
  assign pos_m1   = pos_q - CNT_W'(1);
  assign pos_m2   = pos_q - CNT_W'(2);
  assign out_last = (k_q == len_m1);

  // The list memory holds entries 0 .. len-1 sorted by key. An insertion opens
  // a hole at the end and moves it down while the entry below holds a larger
  // key. The read of the next entry down is issued in the same cycle as the
  // write into the hole, so the two ports never touch the same address, and a
  // new item is only taken in the idle state, after all writes have landed.
  always_comb begin
    state_d   = state_q;
    len_d     = len_q;
    pos_d     = pos_q;
    k_d       = k_q;
    ram_we    = 1'b0;
    ram_waddr = pos_q[ADDR_W-1:0];
    ram_wdata = new_q;
    ram_re    = 1'b0;
    ram_raddr = pos_m2[ADDR_W-1:0];
    capture   = 1'b0;
    out_load  = 1'b0;
    s_axis_tready_o = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          capture = 1'b1;
          if (in_qualify && (len_q == '0)) begin
            // Empty list: the entry lands at the front without a scan.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = in_entry;
            len_d     = CNT_W'(1);
            if (s_axis_tlast_i) begin
              k_d     = '0;
              state_d = ST_EMIT_RD;
            end
          end else if (in_qualify) begin
            ram_re    = 1'b1;
            ram_raddr = len_m1[ADDR_W-1:0];
            pos_d     = len_q;
            state_d   = ST_SHIFT;
          end else if (s_axis_tlast_i && (len_q != '0)) begin
            k_d     = '0;
            state_d = ST_EMIT_RD;
          end
        end
      end

      ST_SHIFT: begin
        ram_we = 1'b1;
        if (ram_rdata.key > new_q.key) begin
          // Move the larger entry up into the hole.
          ram_wdata = ram_rdata;
          pos_d     = pos_m1;
          if (pos_q == CNT_W'(1)) begin
            state_d = ST_PLACE;
          end else begin
            ram_re = 1'b1;
          end
        end else begin
          // Equal or smaller key below: the new entry goes after it.
          len_d = len_q + CNT_W'(1);
          k_d   = '0;
          state_d = last_q ? ST_EMIT_RD : ST_IDLE;
        end
      end

      ST_PLACE: begin
        ram_we  = 1'b1;
        len_d   = len_q + CNT_W'(1);
        k_d     = '0;
        state_d = last_q ? ST_EMIT_RD : ST_IDLE;
      end

      ST_EMIT_RD: begin
        // Read only when the output register is free by the next cycle.
        if (!m_valid_q || m_axis_tready_i) begin
          ram_re    = 1'b1;
          ram_raddr = k_q[ADDR_W-1:0];
          state_d   = ST_EMIT_LD;
        end
      end

      ST_EMIT_LD: begin
        out_load = 1'b1;
        if (out_last) begin
          len_d   = '0;
          state_d = ST_IDLE;
        end else begin
          k_d     = k_q + CNT_W'(1);
          state_d = ST_EMIT_RD;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (out_load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      len_q     <= '0;
      pos_q     <= '0;
      k_q       <= '0;
      last_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      len_q     <= len_d;
      pos_q     <= pos_d;
      k_q       <= k_d;
      m_valid_q <= m_valid_d;
      if (capture) begin
        last_q <= s_axis_tlast_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      new_q <= in_entry;
    end
    if (out_load) begin
      m_data_q <= OUT_DATA_W'({TOTAL_W'(len_q), RANK_W'(k_q), ram_rdata.id});
      m_last_q <= out_last;
    end
  end

  fsps_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_list_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;

`ifndef SYNTHESIS
  // The list never grows past its capacity.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CNT_W'(SLOT_COUNT))
    else $error("list length exceeds capacity");

  // During a scan the hole lies above the front and no higher than the list length.
  a_hole_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SHIFT) |-> ((pos_q != '0) && (pos_q <= len_q)))
    else $error("insertion hole out of range");

  // A readout load never overwrites a result item that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT_LD) |-> !m_valid_q)
    else $error("output register overwritten");

  // The final item of a readout, which carries the highest rank, is presented with final_result set.
  a_last_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last) |=> (m_valid_q && m_last_q))
    else $error("final result flag lost");
`endif

endmodule
